@@ rtl/core/predator_prey_cell_step_macros.svh @@
// Assertion macros for the predator-prey cell engine.
// Included by the top level; depends on nothing else.
`ifndef PREDATOR_PREY_CELL_STEP_MACROS_SVH
`define PREDATOR_PREY_CELL_STEP_MACROS_SVH
// Check a property on every clock edge while out of reset.
`define PPC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on every clock edge, including during reset.
`define PPC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ rtl/core/ppc_pkg.sv @@
// Shared types and constants for the predator-prey cell engine.
// No dependencies.
package ppc_pkg;
    localparam int GRID_WIDTH_DEF = 80;
    localparam int GRID_CELLS_DEF = 4000;
    localparam int IDX_W = 12;
    localparam int REG_IDX_W = 2;
    localparam int DATA_W = 8;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_STEP  = 2'd1,
        OP_READ  = 2'd2,
        OP_RSVD  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_WATER = 2'd0,
        KIND_FISH  = 2'd1,
        KIND_SHARK = 2'd2,
        KIND_BAD   = 2'd3
    } t_kind;

    localparam logic [REG_IDX_W-1:0] REG_FISH_BREED  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SHARK_BREED = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SHARK_START = 2'd2;

    localparam logic [7:0] RST_FISH_BREED  = 8'd10;
    localparam logic [7:0] RST_SHARK_BREED = 8'd50;
    localparam logic [7:0] RST_SHARK_START = 8'd40;

    localparam logic [7:0] SAT_MAX = 8'd255;
    localparam logic [3:0] PERM_MAX = 4'd15;

    function automatic logic [1:0] order_dir(input logic [4:0] pos);
        logic [1:0] d;
        unique case (pos)
            5'd0:  d = 2'd0;  5'd1:  d = 2'd1;  5'd2:  d = 2'd2;  5'd3:  d = 2'd3;
            5'd4:  d = 2'd0;  5'd5:  d = 2'd2;  5'd6:  d = 2'd1;  5'd7:  d = 2'd3;
            5'd8:  d = 2'd0;  5'd9:  d = 2'd3;  5'd10: d = 2'd1;  5'd11: d = 2'd2;
            5'd12: d = 2'd0;  5'd13: d = 2'd2;  5'd14: d = 2'd3;  5'd15: d = 2'd1;
            5'd16: d = 2'd0;  5'd17: d = 2'd1;  5'd18: d = 2'd2;  5'd19: d = 2'd3;
            default: d = 2'd0;
        endcase
        return d;
    endfunction

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] cell_index;
        t_kind            new_kind;
        logic [3:0]       perm_offset;
    } t_in;

    typedef struct packed {
        t_kind            prior_kind;
        logic [IDX_W-1:0] dest_index;
        logic             moved;
        logic             ate;
        logic             died;
        logic             bred;
    } t_out;

    // Controller to datapath commands.
    typedef struct packed {
        logic       load;      // capture input item, start clear of result
        logic       rd_src;    // read source cell
        logic       rd_nb;     // read neighbour nb_sel
        logic [1:0] nb_sel;
        logic       eval_nb;   // evaluate returned neighbour data
        logic       wr_a;      // first write slot
        logic       wr_b;      // second write slot
        logic       out_load;
        logic       clr_wr;    // clear-sweep write
    } t_cmd;

    typedef struct packed {
        logic in_range;
        logic is_step_fish;
        logic is_step_shark;
        logic stop_search;   // fish found water or shark found fish
    } t_stat;
endpackage

@@ rtl/core/ppc_if.sv @@
// Valid/ready channel carrying one payload type.
// No package dependency; the payload type is the parameter T.
interface ppc_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/ppc_datapath.sv @@
// Datapath: cell stores, neighbour address generation, step evaluation.
// Depends on ppc_pkg; driven by ppc_ctrl commands.
module ppc_datapath #(
    parameter int GRID_WIDTH = ppc_pkg::GRID_WIDTH_DEF,
    parameter int GRID_CELLS = ppc_pkg::GRID_CELLS_DEF
) (
    input  logic                  i_clk,
    input  ppc_pkg::t_cmd         i_cmd,
    input  ppc_pkg::t_in          i_item,
    input  logic [ppc_pkg::IDX_W-1:0] i_clr_addr,
    input  logic [7:0]            i_fish_breed,
    input  logic [7:0]            i_shark_breed,
    input  logic [7:0]            i_shark_start,
    output ppc_pkg::t_stat        o_stat,
    output ppc_pkg::t_out         o_result
);
    import ppc_pkg::*;

    localparam logic [IDX_W-1:0] CELLS = IDX_W'(GRID_CELLS);
    localparam logic [IDX_W-1:0] WIDTH = IDX_W'(GRID_WIDTH);

    logic [1:0] mem_kind   [GRID_CELLS];
    logic [7:0] mem_age    [GRID_CELLS];
    logic [7:0] mem_energy [GRID_CELLS];

    t_in              r_item;
    logic [1:0]       r_rd_kind;
    logic [7:0]       r_rd_age, r_rd_energy;
    logic [IDX_W-1:0] r_rd_addr;
    logic             r_rd_src;
    t_kind            r_prior;
    logic [7:0]       r_age, r_energy;
    logic [IDX_W-1:0] r_dest;
    logic             r_found_fish, r_found_water;
    t_out             r_out;

    logic [IDX_W-1:0] rd_addr, nb_addr;
    logic [IDX_W:0]   sum;
    logic [4:0]       pos;
    logic [1:0]       dir;

    // Neighbour address with wrap into the grid.
    always_comb begin
        pos = 5'(r_item.perm_offset) + 5'(i_cmd.nb_sel);
        dir = order_dir(pos);
        unique case (dir)
            2'd0: sum = (r_item.cell_index == '0) ? {1'b0, CELLS} - 1'b1
                                                  : {1'b0, r_item.cell_index} - 1'b1;
            2'd1: sum = {1'b0, r_item.cell_index} + 1'b1;
            2'd2: sum = (r_item.cell_index < WIDTH)
                        ? {1'b0, r_item.cell_index} + {1'b0, CELLS} - {1'b0, WIDTH}
                        : {1'b0, r_item.cell_index} - {1'b0, WIDTH};
            default: sum = {1'b0, r_item.cell_index} + {1'b0, WIDTH};
        endcase
        if (dir[0] && sum >= {1'b0, CELLS}) nb_addr = IDX_W'(sum - {1'b0, CELLS});
        else nb_addr = IDX_W'(sum);
        rd_addr = i_cmd.rd_src ? r_item.cell_index : nb_addr;
    end

    // Step results derived from captured state.
    logic       is_fish, is_shark, moved, ate, died, bred;
    logic [7:0] f_age, s_en, s_en_fin, s_age_fin;
    logic [IDX_W-1:0] dest;
    always_comb begin
        is_fish  = r_item.op == OP_STEP && r_prior == KIND_FISH;
        is_shark = r_item.op == OP_STEP && r_prior == KIND_SHARK;
        f_age    = r_age + 8'd1;
        s_en     = r_energy - 8'd1;
        // only a fish or shark step can leave the addressed cell
        dest     = (is_fish || is_shark) ? r_dest : r_item.cell_index;
        moved    = 1'b0; ate = 1'b0; died = 1'b0; bred = 1'b0;
        s_en_fin = s_en;
        s_age_fin = r_age;
        if (is_fish) begin
            moved = r_found_water;
            bred  = moved && f_age > i_fish_breed;
        end else if (is_shark) begin
            ate   = r_found_fish;
            moved = r_found_fish || r_found_water;
            if (ate) s_en_fin = (s_en == SAT_MAX) ? s_en : s_en + 8'd1;
            else died = s_en == 8'd0;
            if (!died) begin
                bred = moved && r_age >= i_shark_breed;
                s_age_fin = (bred ? 8'd0 : r_age) + 8'd1;
            end
        end
    end

    assign o_stat.in_range      = r_item.cell_index < CELLS;
    assign o_stat.is_step_fish  = is_fish;
    assign o_stat.is_step_shark = is_shark;
    assign o_stat.stop_search   = (is_fish && r_found_water) || (is_shark && r_found_fish);
    assign o_result = r_out;

    // Write port: slot A writes the destination (or the addressed cell for
    // write and a stationary creature); slot B writes the source after a move.
    logic             we;
    logic [IDX_W-1:0] wa;
    logic [1:0]       wk;
    logic [7:0]       wage, wen;
    logic             wen_age, wen_en;
    always_comb begin
        we = 1'b0; wa = r_item.cell_index; wk = KIND_WATER; wage = '0; wen = '0;
        wen_age = 1'b0; wen_en = 1'b0;
        if (i_cmd.clr_wr) begin
            we = 1'b1; wa = i_clr_addr;
        end else if (i_cmd.wr_a) begin
            if (r_item.op == OP_WRITE) begin
                we = 1'b1; wen_age = 1'b1; wen_en = 1'b1;
                wk = (r_item.new_kind == KIND_BAD) ? KIND_WATER : r_item.new_kind;
                wen = i_shark_start;
            end else if (is_fish) begin
                we = 1'b1; wa = dest; wk = KIND_FISH; wage = f_age; wen_age = 1'b1;
            end else if (is_shark) begin
                we = 1'b1; wa = dest; wk = died ? KIND_WATER : KIND_SHARK;
                wage = s_age_fin; wen = s_en_fin; wen_age = 1'b1; wen_en = 1'b1;
            end
        end else if (i_cmd.wr_b && moved) begin
            we = 1'b1;
            if (bred) begin
                wk = is_fish ? KIND_FISH : KIND_SHARK; wen_age = 1'b1;
                wen = i_shark_start; wen_en = is_shark;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_kind[wa] <= wk;
            if (wen_age) mem_age[wa] <= wage;
            if (wen_en) mem_energy[wa] <= wen;
        end
        r_rd_kind   <= mem_kind[rd_addr];
        r_rd_age    <= mem_age[rd_addr];
        r_rd_energy <= mem_energy[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= rd_addr;
        r_rd_src  <= i_cmd.rd_src;
        if (i_cmd.load) begin
            r_item <= i_item;
            r_prior <= KIND_WATER;
            r_dest <= i_item.cell_index;
            r_found_fish <= 1'b0;
            r_found_water <= 1'b0;
        end
        if (i_cmd.eval_nb) begin
            if (r_rd_src) begin
                r_prior  <= t_kind'(r_rd_kind);
                r_age    <= r_rd_age;
                r_energy <= r_rd_energy;
            end else if (r_prior == KIND_FISH) begin
                if (!r_found_water && r_rd_kind == KIND_WATER) begin
                    r_found_water <= 1'b1; r_dest <= r_rd_addr;
                end
            end else if (!r_found_fish) begin
                if (r_rd_kind == KIND_FISH) begin
                    r_found_fish <= 1'b1; r_dest <= r_rd_addr;
                end else if (r_rd_kind == KIND_WATER) begin
                    r_found_water <= 1'b1; r_dest <= r_rd_addr;
                end
            end
        end
        if (i_cmd.out_load) begin
            r_out.prior_kind <= r_prior;
            r_out.dest_index <= dest;
            r_out.moved <= moved;
            r_out.ate   <= ate;
            r_out.died  <= died;
            r_out.bred  <= bred;
        end
    end
endmodule

@@ rtl/core/ppc_ctrl.sv @@
// Controller: handshakes, clearing sweep and step sequencing.
// Depends on ppc_pkg; commands ppc_datapath.
module ppc_ctrl #(
    parameter int GRID_CELLS = ppc_pkg::GRID_CELLS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  ppc_pkg::t_stat i_stat,
    output ppc_pkg::t_cmd o_cmd,
    output logic [ppc_pkg::IDX_W-1:0] o_clr_addr
);
    import ppc_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SRC   = 7'b0000100,
        S_NB    = 7'b0001000,
        S_WA    = 7'b0010000,
        S_WB    = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [IDX_W-1:0] r_clr, n_clr;
    logic [2:0] r_cnt, n_cnt;
    logic r_ov, n_ov;

    assign o_clr_addr  = r_clr;
    assign o_out_valid = r_ov;
    assign o_in_ready  = r_state == S_IDLE;

    always_comb begin
        n_state = r_state; n_clr = r_clr; n_cnt = r_cnt; n_ov = r_ov;
        o_cmd = '0;
        if (r_ov && i_out_ready) n_ov = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == IDX_W'(GRID_CELLS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (o_in_ready && i_in_valid) begin
                    o_cmd.load = 1'b1; n_state = S_SRC;
                end
            end
            S_SRC: begin
                // issue source read; neighbour reads follow, each evaluated next cycle
                if (!i_stat.in_range) n_state = S_OUT;
                else begin
                    o_cmd.rd_src = 1'b1; n_cnt = '0; n_state = S_NB;
                end
            end
            S_NB: begin
                o_cmd.eval_nb = 1'b1;
                o_cmd.rd_nb = 1'b1;
                o_cmd.nb_sel = r_cnt[1:0];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 3'd0) begin
                    // prior kind lands this cycle; decided next cycle
                end else if (!(i_stat.is_step_fish || i_stat.is_step_shark)
                             || i_stat.stop_search || r_cnt == 3'd4) begin
                    o_cmd.rd_nb = 1'b0; n_state = S_WA;
                end
            end
            S_WA: begin
                o_cmd.wr_a = 1'b1; n_state = S_WB;
            end
            S_WB: begin
                o_cmd.wr_b = 1'b1; n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the previous result leaves the output register
                if (!r_ov || i_out_ready) begin
                    o_cmd.out_load = 1'b1; n_ov = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_clr <= '0; r_cnt <= '0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_clr <= n_clr; r_cnt <= n_cnt; r_ov <= n_ov;
        end
    end
endmodule

@@ rtl/core/predator_prey_cell_step.sv @@
// Predator-prey cell engine on a toroidal grid of GRID_CELLS cells. After reset
// the block sweeps the kind store to water before it takes its first item;
// configuration writes are taken throughout. Every item gives one result, and
// no new item is taken until the last one has reached the output register. An
// out-of-range item goes straight to the output; any other item reads its source
// cell, then neighbours through the single store read port (up to four for a fish
// or shark step; the search stops once a fish finds water or a shark finds fish),
// then the write slots. A finished item waits while an earlier result is unaccepted.
`include "predator_prey_cell_step_macros.svh"
module predator_prey_cell_step #(
    parameter int GRID_WIDTH = ppc_pkg::GRID_WIDTH_DEF,
    parameter int GRID_CELLS = ppc_pkg::GRID_CELLS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ppc_if.sink                           in_ch,
    ppc_if.source                         out_ch,
    input  logic                          i_cfg_we,
    input  logic [ppc_pkg::REG_IDX_W-1:0] i_cfg_idx,
    input  logic [ppc_pkg::DATA_W-1:0]    i_cfg_data
);
    import ppc_pkg::*;

    logic [7:0] r_fish_breed, r_shark_breed, r_shark_start;
    t_cmd cmd;
    t_stat stat;
    logic [IDX_W-1:0] clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fish_breed <= RST_FISH_BREED;
            r_shark_breed <= RST_SHARK_BREED;
            r_shark_start <= RST_SHARK_START;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_FISH_BREED) r_fish_breed <= i_cfg_data;
            if (i_cfg_idx == REG_SHARK_BREED) r_shark_breed <= i_cfg_data;
            if (i_cfg_idx == REG_SHARK_START) r_shark_start <= i_cfg_data;
        end
    end

    ppc_ctrl #(.GRID_CELLS(GRID_CELLS)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_stat(stat), .o_cmd(cmd), .o_clr_addr(clr_addr)
    );

    ppc_datapath #(.GRID_WIDTH(GRID_WIDTH), .GRID_CELLS(GRID_CELLS)) u_dp (
        .i_clk, .i_cmd(cmd), .i_item(in_ch.data), .i_clr_addr(clr_addr),
        .i_fish_breed(r_fish_breed), .i_shark_breed(r_shark_breed),
        .i_shark_start(r_shark_start), .o_stat(stat), .o_result(out_ch.data)
    );

    `PPC_ASSERT(a_no_accept_busy, i_clk, i_rst_n, out_ch.valid && !out_ch.ready |=> out_ch.valid, "result dropped")
    `PPC_ASSERT(a_one_write, i_clk, i_rst_n, !(cmd.wr_a && cmd.wr_b) && !(cmd.clr_wr && cmd.load), "command overlap")
    `PPC_ASSERT_ALWAYS(a_no_ready_reset, i_clk, !i_rst_n |=> !in_ch.ready, "ready after reset")
endmodule
